/* rtl/flvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvs_pkg : shared types and constants of the faux light vertex shader
// Item payloads, control bundle, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package flvs_pkg;

  localparam int CH_W      = 9;    // Q1.8 channel, 256 = 1.0
  localparam int NUM_CH    = 4;    // a, r, g, b
  localparam int REG_W     = NUM_CH * CH_W;
  localparam int SCALE_W   = 16;   // unsigned Q.15 scale, up to about 1.73
  localparam int CFG_IDX_W = 3;

  // 1/sqrt(3) in Q0.16, 0.8 in Q0.15
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  localparam logic [14:0] REVERSE_Q15   = 15'd26214;

  localparam logic [REG_W-1:0] LITE_RST = 36'd34426978560;
  localparam logic [REG_W-1:0] DARK_RST = 36'd34359738368;
  localparam logic [REG_W-1:0] MULT_RST = 36'd34426978560;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LITE_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHADE_ENABLE = 3'd4;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [CH_W-1:0]    orig_red;
    logic [CH_W-1:0]    orig_green;
    logic [CH_W-1:0]    orig_blue;
    logic [CH_W-1:0]    orig_alpha;
    logic               orig_valid;
    logic               last_vertex;
  } in_t;

  typedef struct packed {
    logic [31:0] packed_color;
    logic        last_out;
  } out_t;

  // control that travels with an item
  typedef struct packed {
    logic vld;
    logic shade;
    logic orig_valid;
    logic use_mult;
    logic last;
  } ctl_t;

endpackage

/* rtl/flvs_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvs_scale : light scale from the vertex normal
// Three stages: sum and magnitude, 1/sqrt(3) multiply, back-face 0.8 multiply.
// ----------------------------------------------------------------------------
module flvs_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  flvs_pkg::ctl_t                 ctl_i,
  input  logic signed [15:0]             nx_i,
  input  logic signed [15:0]             ny_i,
  input  logic signed [15:0]             nz_i,
  output flvs_pkg::ctl_t                 ctl_o,
  output logic [flvs_pkg::SCALE_W-1:0]   scale_o
);

  flvs_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r;

  logic signed [17:0] sum;
  logic [16:0]        mag1_nxt, mag1_r;
  logic               neg1_r, neg2_r;
  logic [32:0]        prod2;
  logic [flvs_pkg::SCALE_W-1:0] m2_r;
  logic [31:0]        prod3;
  logic [flvs_pkg::SCALE_W-1:0] m3_nxt, m3_r;

  // stage 1: s = nx + ny + nz, exact
  assign sum = {{2{nx_i[15]}}, nx_i} + {{2{ny_i[15]}}, ny_i} + {{2{nz_i[15]}}, nz_i};
  assign mag1_nxt = sum[17] ? 17'(-sum) : sum[16:0];

  // stage 2: round(|s| / sqrt(3)), half up
  assign prod2 = 33'(mag1_r * flvs_pkg::INV_SQRT3_Q16) + 33'd32768;

  // stage 3: negative side is weakened by 0.8
  assign prod3 = 32'(m2_r * flvs_pkg::REVERSE_Q15) + 32'd16384;
  assign m3_nxt = neg2_r ? prod3[30:15] : m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r <= mag1_nxt;
    neg1_r <= sum[17];
    m2_r   <= prod2[31:16];
    neg2_r <= neg1_r;
    m3_r   <= m3_nxt;
  end

  assign ctl_o   = ctl3_r;
  assign scale_o = m3_r;

endmodule

/* rtl/flvs_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvs_lane : one color channel
// Four stages: lite/dark blend, original color multiply, tint multiply,
// clamp and scale to a byte. Unused multiplies take 1.0 (256).
// ----------------------------------------------------------------------------
module flvs_lane (
  input  logic                           clk,
  input  flvs_pkg::ctl_t                 ctl_i,
  input  logic [flvs_pkg::SCALE_W-1:0]   scale_i,
  input  logic [flvs_pkg::CH_W-1:0]      orig_i,
  input  logic [flvs_pkg::CH_W-1:0]      lite_i,
  input  logic [flvs_pkg::CH_W-1:0]      dark_i,
  input  logic [flvs_pkg::CH_W-1:0]      mult_i,
  output logic [7:0]                     byte_o
);

  localparam logic signed [9:0] ONE_Q8 = 10'sd256;

  logic signed [9:0]  diff;
  logic signed [26:0] blend_prod;
  logic signed [27:0] v4_nxt, v4_r;
  logic               use_orig4_r, use_mult4_r, use_mult5_r;
  logic [flvs_pkg::CH_W-1:0] orig4_r;
  logic signed [9:0]  fac5, fac6;
  logic signed [37:0] v5_r;
  logic signed [47:0] v6_r;
  logic [46:0]        x255;
  logic [7:0]         byte7_nxt, byte7_r;

  // stage 4: dark*2^15 + (lite - dark)*m, Q.23; pass mode loads orig as Q.23
  assign diff       = $signed({1'b0, lite_i}) - $signed({1'b0, dark_i});
  assign blend_prod = diff * $signed({1'b0, scale_i});
  always_comb begin
    if (ctl_i.shade) begin
      v4_nxt = $signed({4'd0, dark_i, 15'd0}) + 28'(blend_prod);
    end else if (ctl_i.orig_valid) begin
      v4_nxt = $signed({4'd0, orig_i, 15'd0});
    end else begin
      v4_nxt = '0;
    end
  end

  // stage 5 and 6 factors
  assign fac5 = use_orig4_r ? $signed({1'b0, orig4_r}) : ONE_Q8;
  assign fac6 = use_mult5_r ? $signed({1'b0, mult_i}) : ONE_Q8;

  // stage 7: value has 39 fraction bits
  assign x255 = {v6_r[38:0], 8'd0} - {8'd0, v6_r[38:0]};
  always_comb begin
    if (v6_r[47] || v6_r == '0) begin
      byte7_nxt = 8'd0;
    end else if (|v6_r[46:39]) begin
      byte7_nxt = 8'd255;
    end else begin
      byte7_nxt = x255[46:39];
    end
  end

  always_ff @(posedge clk) begin
    v4_r        <= v4_nxt;
    use_orig4_r <= ctl_i.shade & ctl_i.orig_valid;
    use_mult4_r <= ctl_i.shade & ctl_i.use_mult;
    orig4_r     <= orig_i;
    v5_r        <= v4_r * fac5;
    use_mult5_r <= use_mult4_r;
    v6_r        <= v5_r * fac6;
    byte7_r     <= byte7_nxt;
  end

  assign byte_o = byte7_r;

endmodule

/* rtl/faux_light_vertex_shader_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faux_light_vertex_shader_core : two-sided faux light vertex shader
// Shades one vertex per clock from its normal and optional color, ARGB8888 out.
// ----------------------------------------------------------------------------
// channel   ports                            transfer
// -------   -------------------------------  ---------------------------------
// input     start, busy, in_data             item taken when start && !busy
// result    out_valid, out_data              one-cycle strobe, no back pressure
// config    cfg_we, cfg_index, cfg_wdata     register written when cfg_we
//
// A new item
// is taken every clock, so busy is always low.
// Depth is set by the scale path (3 stages) and the per-channel lane
// (blend, two multiplies, clamp).
// Synchronous active-low reset clears valid bits and loads register defaults.
// The receiver cannot stall; the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module faux_light_vertex_shader_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  flvs_pkg::in_t                       in_data,
  output logic                                out_valid,
  output flvs_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [flvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [flvs_pkg::REG_W-1:0]          cfg_wdata
);

  localparam int CH_W   = flvs_pkg::CH_W;
  localparam int NUM_CH = flvs_pkg::NUM_CH;

  // configuration registers
  logic [flvs_pkg::REG_W-1:0] lite_r, dark_r, mult_r;
  logic                       mult_en_r, shade_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lite_r     <= flvs_pkg::LITE_RST;
      dark_r     <= flvs_pkg::DARK_RST;
      mult_r     <= flvs_pkg::MULT_RST;
      mult_en_r  <= 1'b0;
      shade_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        flvs_pkg::CFG_LITE_COLOR:   lite_r     <= cfg_wdata;
        flvs_pkg::CFG_DARK_COLOR:   dark_r     <= cfg_wdata;
        flvs_pkg::CFG_MULT_COLOR:   mult_r     <= cfg_wdata;
        flvs_pkg::CFG_MULT_ENABLE:  mult_en_r  <= cfg_wdata[0];
        flvs_pkg::CFG_SHADE_ENABLE: shade_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // fully pipelined: always ready
  assign busy = 1'b0;

  // control entering the pipe
  flvs_pkg::ctl_t ctl_in, ctl3;
  always_comb begin
    ctl_in.vld        = start;
    ctl_in.shade      = shade_en_r;
    ctl_in.orig_valid = in_data.orig_valid;
    ctl_in.use_mult   = mult_en_r;
    ctl_in.last       = in_data.last_vertex;
  end

  logic [flvs_pkg::SCALE_W-1:0] scale3;

  flvs_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_in),
    .nx_i    (in_data.normal_x),
    .ny_i    (in_data.normal_y),
    .nz_i    (in_data.normal_z),
    .ctl_o   (ctl3),
    .scale_o (scale3)
  );

  // original color in a,r,g,b order, delayed to line up with the scale
  logic [NUM_CH-1:0][CH_W-1:0] orig0, orig1_r, orig2_r, orig3_r;
  assign orig0 = {in_data.orig_alpha, in_data.orig_red,
                  in_data.orig_green, in_data.orig_blue};

  always_ff @(posedge clk) begin
    orig1_r <= orig0;
    orig2_r <= orig1_r;
    orig3_r <= orig2_r;
  end

  // valid and last ride alongside the lanes (stages 4..7)
  logic [3:0] vld_r;
  logic [3:0] last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], ctl3.vld};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[2:0], ctl3.last};
  end

  // four channel lanes, index 0 = alpha (top of the packed registers)
  logic [NUM_CH-1:0][7:0] bytes;

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    flvs_lane u_lane (
      .clk     (clk),
      .ctl_i   (ctl3),
      .scale_i (scale3),
      .orig_i  (orig3_r[NUM_CH-1-i]),
      .lite_i  (lite_r[(NUM_CH-i)*CH_W-1 -: CH_W]),
      .dark_i  (dark_r[(NUM_CH-i)*CH_W-1 -: CH_W]),
      .mult_i  (mult_r[(NUM_CH-i)*CH_W-1 -: CH_W]),
      .byte_o  (bytes[NUM_CH-1-i])
    );
  end

  assign out_valid             = vld_r[3];
  assign out_data.packed_color = bytes;
  assign out_data.last_out     = last_r[3];

endmodule

/* bench/faux_light_vertex_shader_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faux_light_vertex_shader_core_tb : self-checking bench for the vertex shader
// Streams vertices through the core under several register settings, predicts
// every ARGB8888 color in fixed point and compares it with what comes out.
// ----------------------------------------------------------------------------
module faux_light_vertex_shader_core_tb;

  localparam int CH_W      = flvs_pkg::CH_W;
  localparam int NUM_CH    = flvs_pkg::NUM_CH;
  localparam int REG_W     = flvs_pkg::REG_W;
  localparam int CFG_IDX_W = flvs_pkg::CFG_IDX_W;

  // --------------------------------------------------------------------------
  // Expected-color bookkeeping. Holds its own copy of the shader registers,
  // shades each accepted vertex and queues the color it must produce.
  // --------------------------------------------------------------------------
  class shade_scoreboard;
    logic [REG_W-1:0] lite_c;
    logic [REG_W-1:0] dark_c;
    logic [REG_W-1:0] tint_c;
    bit               tint_on;
    bit               shade_on;
    flvs_pkg::out_t   pending_colors[$];
    int               errors;
    int               checked;

    function new();
      lite_c   = flvs_pkg::LITE_RST;
      dark_c   = flvs_pkg::DARK_RST;
      tint_c   = flvs_pkg::MULT_RST;
      tint_on  = 1'b0;
      shade_on = 1'b1;
      errors   = 0;
      checked  = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        flvs_pkg::CFG_LITE_COLOR:   lite_c   = val;
        flvs_pkg::CFG_DARK_COLOR:   dark_c   = val;
        flvs_pkg::CFG_MULT_COLOR:   tint_c   = val;
        flvs_pkg::CFG_MULT_ENABLE:  tint_on  = val[0];
        flvs_pkg::CFG_SHADE_ENABLE: shade_on = val[0];
        default: ;
      endcase
    endfunction

    // clamp to [0,1] with frac fraction bits, then scale to 0..255 and truncate
    static function logic [7:0] sat_byte(longint v, int frac);
      longint one;
      longint prod;
      one = longint'(1) <<< frac;
      if (v <= 0) return 8'd0;
      if (v >= one) return 8'd255;
      prod = (v * 255) >>> frac;
      return prod[7:0];
    endfunction

    function flvs_pkg::out_t shade_vertex(flvs_pkg::in_t vx);
      longint          sum;
      longint          mag;
      longint          scale;
      longint          lt;
      longint          dk;
      longint          v;
      int              frac;
      logic [CH_W-1:0] orig [NUM_CH];
      logic [7:0]      bytes [NUM_CH];
      flvs_pkg::out_t  res;
      // channel order a, r, g, b
      orig[0] = vx.orig_alpha;
      orig[1] = vx.orig_red;
      orig[2] = vx.orig_green;
      orig[3] = vx.orig_blue;
      if (shade_on) begin
        sum = longint'(vx.normal_x) + longint'(vx.normal_y) + longint'(vx.normal_z);
        mag = (sum < 0) ? -sum : sum;
        scale = (mag * longint'(flvs_pkg::INV_SQRT3_Q16) + 32768) >>> 16;
        // back side: weaker light at 0.8
        if (sum < 0) scale = (scale * longint'(flvs_pkg::REVERSE_Q15) + 16384) >>> 15;
        for (int i = 0; i < NUM_CH; i++) begin
          lt   = longint'(lite_c[REG_W-1-CH_W*i -: CH_W]);
          dk   = longint'(dark_c[REG_W-1-CH_W*i -: CH_W]);
          v    = dk * 32768 + (lt - dk) * scale;
          frac = 23;
          if (vx.orig_valid) begin
            v    = v * longint'(orig[i]);
            frac = frac + 8;
          end
          if (tint_on) begin
            v    = v * longint'(tint_c[REG_W-1-CH_W*i -: CH_W]);
            frac = frac + 8;
          end
          bytes[i] = sat_byte(v, frac);
        end
      end else begin
        // pass mode: no tint, and no color at all without orig_valid
        for (int i = 0; i < NUM_CH; i++)
          bytes[i] = vx.orig_valid ? sat_byte(longint'(orig[i]), 8) : 8'd0;
      end
      res.packed_color = {bytes[0], bytes[1], bytes[2], bytes[3]};
      res.last_out     = vx.last_vertex;
      return res;
    endfunction

    function void note_vertex(flvs_pkg::in_t vx);
      pending_colors.push_back(shade_vertex(vx));
    endfunction

    function void check_color(flvs_pkg::out_t got);
      flvs_pkg::out_t want;
      if (pending_colors.size() == 0) begin
        errors++;
        $display("%0t: color expected none actual %h last %b",
                 $time, got.packed_color, got.last_out);
        return;
      end
      want = pending_colors.pop_front();
      checked++;
      if (got.packed_color !== want.packed_color) begin
        errors++;
        $display("%0t: packed_color expected %h actual %h",
                 $time, want.packed_color, got.packed_color);
      end
      if (got.last_out !== want.last_out) begin
        errors++;
        $display("%0t: last_out expected %b actual %b",
                 $time, want.last_out, got.last_out);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  flvs_pkg::in_t        in_data;
  logic                 out_valid;
  flvs_pkg::out_t       out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  shade_scoreboard sb;
  int              items_sent;
  int              directed_items;
  int              settings_used;

  faux_light_vertex_shader_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Results are a one-cycle strobe with no back pressure; sample the values
  // that stood before the edge and hand them to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_color(out_data);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // mostly legal Q1.8 channels, sometimes above 1.0 up to the full 9 bits
  function automatic logic [CH_W-1:0] rand_chan();
    if ($urandom_range(0, 9) < 7) return CH_W'($urandom_range(0, 256));
    return CH_W'($urandom_range(0, 511));
  endfunction

  function automatic logic [REG_W-1:0] rand_color_reg();
    return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic flvs_pkg::in_t mk_vertex(int nx, int ny, int nz,
                                              int r, int g, int b, int a,
                                              bit valid, bit last);
    flvs_pkg::in_t vx;
    vx.normal_x    = 16'(nx);
    vx.normal_y    = 16'(ny);
    vx.normal_z    = 16'(nz);
    vx.orig_red    = CH_W'(r);
    vx.orig_green  = CH_W'(g);
    vx.orig_blue   = CH_W'(b);
    vx.orig_alpha  = CH_W'(a);
    vx.orig_valid  = valid;
    vx.last_vertex = last;
    return vx;
  endfunction

  // Normals: half fully random bits, some with every component within +-1/sqrt(3),
  // the rest axis extremes so the scale saturates both ways.
  function automatic flvs_pkg::in_t rand_vertex();
    int n [3];
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (mode < 5)
        n[k] = int'($urandom_range(0, 65535));
      else if (mode < 8)
        n[k] = int'($urandom_range(0, 37836)) - 18918;
      else
        case ($urandom_range(0, 2))
          0:       n[k] = -32768;
          1:       n[k] = 32767;
          default: n[k] = 0;
        endcase
    end
    return mk_vertex(n[0], n[1], n[2], rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                     $urandom_range(0, 1), $urandom_range(0, 7) == 0);
  endfunction

  // Hold start high until the core takes the vertex, then log it.
  task automatic send_item(flvs_pkg::in_t vx);
    start   <= 1'b1;
    in_data <= vx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_vertex(vx);
    items_sent++;
  endtask

  // Sender idles in about 27 of 100 cycles: a gap before about
  // 15 of 100 items. Junk on in_data while start is low.
  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 99) < 15) begin
      start   <= 1'b0;
      in_data <= rand_vertex();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Writes all five registers back to back; only called with the core idle.
  // Enable registers get random upper bits, only bit 0 counts.
  task automatic set_config(logic [REG_W-1:0] lite, logic [REG_W-1:0] dark,
                            logic [REG_W-1:0] tint, bit tint_en, bit shade_en);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [REG_W-1:0]     val [5];
    idx[0] = flvs_pkg::CFG_LITE_COLOR;   val[0] = lite;
    idx[1] = flvs_pkg::CFG_DARK_COLOR;   val[1] = dark;
    idx[2] = flvs_pkg::CFG_MULT_COLOR;   val[2] = tint;
    idx[3] = flvs_pkg::CFG_MULT_ENABLE;  val[3] = {4'($urandom()), $urandom()};
    idx[4] = flvs_pkg::CFG_SHADE_ENABLE; val[4] = {4'($urandom()), $urandom()};
    val[3][0] = tint_en;
    val[4][0] = shade_en;
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      sb.load_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Wait until every queued color has come back, then let the 7-deep pipe
  // settle before touching registers.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_colors.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb             = new();
    items_sent     = 0;
    settings_used  = 0;
    directed_items = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_data        <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= flvs_pkg::CFG_LITE_COLOR;
    cfg_wdata      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values: white lite, black dark, no tint.
    send_item(mk_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_vertex(32767, 32767, 32767, 256, 256, 256, 256, 1, 1));     // max scale
    send_item(mk_vertex(-32768, -32768, -32768, 0, 0, 0, 0, 1, 0));          // most negative
    send_item(mk_vertex(18918, 18918, 18918, 256, 128, 64, 200, 1, 0));      // facing light
    send_item(mk_vertex(-18918, -18918, -18918, 256, 128, 64, 200, 1, 0));   // back side
    send_item(mk_vertex(32767, -32768, 0, 100, 100, 100, 100, 1, 0));        // sum of -1
    send_item(mk_vertex(1, 0, 0, 256, 256, 256, 256, 1, 0));
    send_item(mk_vertex(-1, 0, 0, 256, 256, 256, 256, 1, 0));
    send_item(mk_vertex(10000, 5000, -3000, 511, 511, 511, 511, 1, 0));      // above 1.0
    send_item(mk_vertex(-7000, 20000, 1234, 128, 64, 32, 255, 1, 0));
    send_item(mk_vertex(0, 0, 32767, 511, 0, 256, 1, 0, 1));                 // no color
    drain();

    // Directed, extreme lite/dark with tint on.
    set_config({REG_W{1'b1}}, '0, rand_color_reg(), 1'b1, 1'b1);
    send_item(mk_vertex(32767, 32767, 32767, 511, 511, 511, 511, 1, 0));
    send_item(mk_vertex(-32768, -32768, -32768, 256, 256, 256, 256, 1, 1));
    send_item(mk_vertex(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_vertex(5000, -20000, 7000, 300, 17, 256, 90, 1, 0));
    drain();

    // Directed pass mode: tint of zero must not show, nor must the normal.
    set_config(rand_color_reg(), rand_color_reg(), '0, 1'b1, 1'b0);
    send_item(mk_vertex(32767, 32767, 32767, 256, 256, 256, 256, 1, 0));
    send_item(mk_vertex(-32768, 0, 0, 511, 511, 511, 511, 1, 0));
    send_item(mk_vertex(0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_item(mk_vertex(1234, -4321, 99, 300, 200, 100, 50, 0, 1));          // no color
    send_item(mk_vertex(-3, 8000, -16000, 1, 128, 255, 300, 1, 1));
    drain();
    directed_items = items_sent;

    // Random phases: extremes first, then random settings. Phase 4 runs
    // without any sender gaps.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config('0, {REG_W{1'b1}}, {REG_W{1'b1}}, 1'b0, 1'b1);
        1: set_config({REG_W{1'b1}}, '0, {REG_W{1'b1}}, 1'b1, 1'b1);
        3: set_config(rand_color_reg(), rand_color_reg(), rand_color_reg(), 1'b1, 1'b0);
        default:
          set_config(rand_color_reg(), rand_color_reg(), rand_color_reg(),
                     $urandom_range(0, 1), $urandom_range(0, 4) != 0);
      endcase
      for (int n = 0; n < 225; n++) begin
        maybe_idle(p != 4);
        send_item(rand_vertex());
      end
      drain();
    end

    $display("Shaded %0d vertices (%0d directed) under %0d register settings plus reset values",
             items_sent, directed_items, settings_used);
    $display("%0d colors compared, %0d field errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop; a correct run needs well under a tenth of this.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* faux_light_vertex_shader_core.f */
rtl/flvs_pkg.sv
rtl/flvs_scale.sv
rtl/flvs_lane.sv
rtl/faux_light_vertex_shader_core.sv
bench/faux_light_vertex_shader_core_tb.sv
